// File: sv/vga_dac_palette_ports_unit_defines.svh
// assertion macros for the vga palette port block
// expects clk and arst_n in the scope of each use
`ifndef VGA_DAC_PALETTE_PORTS_UNIT_DEFINES_SVH
`define VGA_DAC_PALETTE_PORTS_UNIT_DEFINES_SVH

// same-cycle implication
`define VDP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette port check failed");

// next-cycle implication
`define VDP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette port check failed");

`endif

// File: sv/vdp_pkg.sv
// shared types and constants for the vga palette port block
// port numbers, word layouts and the default palette table; no dependencies
package vdp_pkg;

	typedef struct packed {
		logic        command;
		logic [15:0] port;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [17:0] plane_offset;
		logic [2:0]  planar_bits;
	} rsp_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [15:0] PORT_ATTR     = 16'h03C0;
	localparam logic [15:0] PORT_SEQ_IDX  = 16'h03C4;
	localparam logic [15:0] PORT_SEQ_DATA = 16'h03C5;
	localparam logic [15:0] PORT_DAC_RIDX = 16'h03C7;
	localparam logic [15:0] PORT_DAC_WIDX = 16'h03C8;
	localparam logic [15:0] PORT_DAC_DATA = 16'h03C9;

	localparam logic [7:0] SEQ_MAP_MASK = 8'd2;
	localparam logic [7:0] SEQ_MEM_MODE = 8'd4;

	localparam logic [7:0] READ_NONE = 8'hFF;

	localparam logic [1:0] PHASE_RED   = 2'd0;
	localparam logic [1:0] PHASE_GREEN = 2'd1;
	localparam logic [1:0] PHASE_BLUE  = 2'd2;

	localparam logic [23:0] DEFAULT_PALETTE [256] = '{
		24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
		24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
		24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
		24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF,
		24'h000000, 24'h141414, 24'h202020, 24'h2C2C2C,
		24'h383838, 24'h444444, 24'h505050, 24'h606060,
		24'h707070, 24'h808080, 24'h909090, 24'hA0A0A0,
		24'hB4B4B4, 24'hC8C8C8, 24'hDCDCDC, 24'hF0F0F0,
		24'h0000FF, 24'h4100FF, 24'h8200FF, 24'hBE00FF,
		24'hFF00FF, 24'hFF00BE, 24'hFF0082, 24'hFF0041,
		24'hFF0000, 24'hFF4100, 24'hFF8200, 24'hFFBE00,
		24'hFFFF00, 24'hBEFF00, 24'h82FF00, 24'h41FF00,
		24'h00FF00, 24'h00FF41, 24'h00FF82, 24'h00FFBE,
		24'h00FFFF, 24'h00BEFF, 24'h0082FF, 24'h0041FF,
		24'h8282FF, 24'h9E82FF, 24'hBE82FF, 24'hDB82FF,
		24'hFF82FF, 24'hFF82DB, 24'hFF82BE, 24'hFF829E,
		24'hFF8282, 24'hFF9E82, 24'hFFBE82, 24'hFFDB82,
		24'hFFFF82, 24'hDBFF82, 24'hBEFF82, 24'h9EFF82,
		24'h82FF82, 24'h82FF9E, 24'h82FFBE, 24'h82FFDB,
		24'h82FFFF, 24'h82DBFF, 24'h82BEFF, 24'h829EFF,
		24'hB6B6FF, 24'hC6B6FF, 24'hDBB6FF, 24'hEBB6FF,
		24'hFFB6FF, 24'hFFB6EB, 24'hFFB6DB, 24'hFFB6C6,
		24'hFFB6B6, 24'hFFC6B6, 24'hFFDBB6, 24'hFFEBB6,
		24'hFFFFB6, 24'hEBFFB6, 24'hDBFFB6, 24'hC6FFB6,
		24'hB6FFB6, 24'hB6FFC6, 24'hB6FFDB, 24'hB6FFEB,
		24'hB6FFFF, 24'hB6EBFF, 24'hB6DBFF, 24'hB6C6FF,
		24'h000071, 24'h1C0071, 24'h390071, 24'h550071,
		24'h710071, 24'h710055, 24'h710039, 24'h71001C,
		24'h710000, 24'h711C00, 24'h713900, 24'h715500,
		24'h717100, 24'h557100, 24'h397100, 24'h1C7100,
		24'h007100, 24'h00711C, 24'h007139, 24'h007155,
		24'h007171, 24'h005571, 24'h003971, 24'h001C71,
		24'h393971, 24'h453971, 24'h553971, 24'h613971,
		24'h713971, 24'h713961, 24'h713955, 24'h713945,
		24'h713939, 24'h714539, 24'h715539, 24'h716139,
		24'h717139, 24'h617139, 24'h557139, 24'h457139,
		24'h397139, 24'h397145, 24'h397155, 24'h397161,
		24'h397171, 24'h396171, 24'h395571, 24'h394571,
		24'h515171, 24'h595171, 24'h615171, 24'h695171,
		24'h715171, 24'h715169, 24'h715161, 24'h715159,
		24'h715151, 24'h715951, 24'h716151, 24'h716951,
		24'h717151, 24'h697151, 24'h617151, 24'h597151,
		24'h517151, 24'h517159, 24'h517161, 24'h517169,
		24'h517171, 24'h516971, 24'h516171, 24'h515971,
		24'h000041, 24'h100041, 24'h200041, 24'h310041,
		24'h410041, 24'h410031, 24'h410020, 24'h410010,
		24'h410000, 24'h411000, 24'h412000, 24'h413100,
		24'h414100, 24'h314100, 24'h204100, 24'h104100,
		24'h004100, 24'h004110, 24'h004120, 24'h004131,
		24'h004141, 24'h003141, 24'h002041, 24'h001041,
		24'h202041, 24'h282041, 24'h312041, 24'h392041,
		24'h412041, 24'h412039, 24'h412031, 24'h412028,
		24'h412020, 24'h412820, 24'h413120, 24'h413920,
		24'h414120, 24'h394120, 24'h314120, 24'h284120,
		24'h204120, 24'h204128, 24'h204131, 24'h204139,
		24'h204141, 24'h203941, 24'h203141, 24'h202841,
		24'h2D2D41, 24'h312D41, 24'h392D41, 24'h3D2D41,
		24'h412D41, 24'h412D3D, 24'h412D39, 24'h412D31,
		24'h412D2D, 24'h41312D, 24'h41392D, 24'h413D2D,
		24'h41412D, 24'h3D412D, 24'h39412D, 24'h31412D,
		24'h2D412D, 24'h2D4131, 24'h2D4139, 24'h2D413D,
		24'h2D4141, 24'h2D3D41, 24'h2D3941, 24'h2D3141,
		24'h000000, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000
	};

	// two-bit ega component scaled to the full byte range
	function automatic logic [7:0] ega_component(input logic hi, input logic lo);
		logic [7:0] v;
		case ({hi, lo})
			2'b00:   v = 8'd0;
			2'b01:   v = 8'd85;
			2'b10:   v = 8'd170;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

endpackage

// File: sv/vga_dac_palette_ports_unit.sv
// vga attribute, sequencer and dac palette ports over one 256 x 24 palette ram
// one result word per request word, held in a registered result word; a dac data read passes
// first through the synchronous palette ram read register; throughput 1 word per cycle while the
// result side takes words, and a dac data read holds off the next request until it completes
// reset: asynchronous; palette valid bits clear at once so entries read the default table
`include "vga_dac_palette_ports_unit_defines.svh"

module vga_dac_palette_ports_unit import vdp_pkg::*; #(
	parameter int PLANE_SIZE = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	localparam logic [17:0] PLANE_STEP = 18'(PLANE_SIZE);

	logic        state_q;
	logic        attr_data_phase_q;
	logic [3:0]  attr_index_q;
	logic [7:0]  seq_index_q;
	logic [7:0]  dac_write_index_q;
	logic [7:0]  dac_read_index_q;
	logic [1:0]  write_phase_q;
	logic [15:0] pending_q;
	logic [1:0]  read_phase_q;
	logic [1:0]  plane_q;
	logic [2:0]  planar_q;
	logic [255:0] pal_valid_q;

	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [23:0] pal_mem [256];
	logic [23:0] pal_rdata_s1;
	logic        pal_hit_s1;
	logic [7:0]  rd_index_s1;
	logic [1:0]  rd_phase_s1;

	logic        acc;
	logic        is_rd;
	logic        pal_rd;
	logic        pal_we;
	logic [7:0]  pal_waddr;
	logic [23:0] pal_wdata;
	logic [7:0]  dac_comp;
	logic [1:0]  plane_d;
	logic [2:0]  planar_d;
	logic [7:0]  rd_direct;
	logic [23:0] rd_entry;
	logic [5:0]  rd_comp;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign acc       = req_valid && req_ready;
	assign is_rd     = (req.command == CMD_READ);
	assign pal_rd    = acc && is_rd && (req.port == PORT_DAC_DATA);
	assign dac_comp  = {req.data[5:0], 2'b00};

	always_comb begin
		pal_we    = 1'b0;
		pal_waddr = dac_write_index_q;
		pal_wdata = {pending_q, dac_comp};
		if (acc && !is_rd) begin
			if (req.port == PORT_ATTR && attr_data_phase_q) begin
				pal_we    = 1'b1;
				pal_waddr = {4'b0000, attr_index_q};
				pal_wdata = {ega_component(req.data[2], req.data[5]),
				             ega_component(req.data[1], req.data[4]),
				             ega_component(req.data[0], req.data[3])};
			end else if (req.port == PORT_DAC_DATA && write_phase_q == PHASE_BLUE) begin
				pal_we = 1'b1;
			end
		end
	end

	// plane and mode as they stand after this word
	always_comb begin
		plane_d  = plane_q;
		planar_d = planar_q;
		if (!is_rd && req.port == PORT_SEQ_DATA) begin
			if (seq_index_q == SEQ_MAP_MASK) begin
				unique case (req.data[3:0])
					4'b0010: plane_d = 2'd1;
					4'b0100: plane_d = 2'd2;
					4'b1000: plane_d = 2'd3;
					default: plane_d = 2'd0;
				endcase
			end
			if (seq_index_q == SEQ_MEM_MODE) begin
				planar_d = {req.data[2:1], 1'b0};
			end
		end
	end

	always_comb begin
		rd_direct = 8'h00;
		if (is_rd) begin
			rd_direct = (req.port == PORT_DAC_WIDX) ? dac_write_index_q : READ_NONE;
		end
	end

	assign rd_entry = pal_hit_s1 ? pal_rdata_s1 : DEFAULT_PALETTE[rd_index_s1];

	always_comb begin
		case (rd_phase_s1)
			PHASE_RED:   rd_comp = rd_entry[23:18];
			PHASE_GREEN: rd_comp = rd_entry[15:10];
			default:     rd_comp = rd_entry[7:2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			attr_data_phase_q <= 1'b0;
			attr_index_q      <= '0;
			seq_index_q       <= '0;
			dac_write_index_q <= '0;
			dac_read_index_q  <= '0;
			write_phase_q     <= PHASE_RED;
			pending_q         <= '0;
			read_phase_q      <= PHASE_RED;
			plane_q           <= '0;
			planar_q          <= '0;
			pal_valid_q       <= '0;
			rsp_valid_q       <= 1'b0;
		end else begin
			if (acc) begin
				plane_q  <= plane_d;
				planar_q <= planar_d;
				if (!is_rd) begin
					unique case (req.port)
						PORT_ATTR: begin
							if (!attr_data_phase_q) begin
								attr_index_q <= req.data[3:0];
							end
							attr_data_phase_q <= !attr_data_phase_q;
						end
						PORT_SEQ_IDX:  seq_index_q       <= req.data;
						PORT_DAC_RIDX: dac_read_index_q  <= req.data;
						PORT_DAC_WIDX: dac_write_index_q <= req.data;
						PORT_DAC_DATA: begin
							unique case (write_phase_q)
								PHASE_RED: begin
									pending_q[15:8] <= dac_comp;
									write_phase_q   <= PHASE_GREEN;
								end
								PHASE_GREEN: begin
									pending_q[7:0] <= dac_comp;
									write_phase_q  <= PHASE_BLUE;
								end
								default: begin
									dac_write_index_q <= dac_write_index_q + 8'd1;
									write_phase_q     <= PHASE_RED;
								end
							endcase
						end
						default: ;
					endcase
				end else if (pal_rd) begin
					if (read_phase_q == PHASE_RED) begin
						read_phase_q <= PHASE_GREEN;
					end else if (read_phase_q == PHASE_GREEN) begin
						read_phase_q <= PHASE_BLUE;
					end else begin
						read_phase_q     <= PHASE_RED;
						dac_read_index_q <= dac_read_index_q + 8'd1;
					end
				end
			end
			if (pal_we) begin
				pal_valid_q[pal_waddr] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE:  state_q <= pal_rd ? S_READ : S_IDLE;
				default: state_q <= S_IDLE;
			endcase

			if ((acc && !pal_rd) || state_q == S_READ) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// palette ram and its registered read side
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pal_waddr] <= pal_wdata;
		end
		if (pal_rd) begin
			pal_rdata_s1 <= pal_mem[dac_read_index_q];
			pal_hit_s1   <= pal_valid_q[dac_read_index_q];
			rd_index_s1  <= dac_read_index_q;
			rd_phase_s1  <= read_phase_q;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rsp_q.read_data    <= {2'b00, rd_comp};
			rsp_q.plane_offset <= 18'({16'd0, plane_q} * PLANE_STEP);
			rsp_q.planar_bits  <= planar_q;
		end else if (acc) begin
			rsp_q.read_data    <= rd_direct;
			rsp_q.plane_offset <= 18'({16'd0, plane_d} * PLANE_STEP);
			rsp_q.planar_bits  <= planar_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`VDP_ASSERT_NEXT(a_read_one_cycle, state_q == S_READ, state_q == S_IDLE)
	`VDP_ASSERT_NOW(a_read_slot_free, state_q == S_READ, !rsp_valid_q)
	`VDP_ASSERT_NEXT(a_direct_word_shown, acc && !pal_rd, rsp_valid_q && state_q == S_IDLE)
	`VDP_ASSERT_NEXT(a_palette_read_shown, state_q == S_READ, rsp_valid_q)
	`VDP_ASSERT_NOW(a_write_phase_range, 1'b1, write_phase_q != 2'd3 && read_phase_q != 2'd3)

endmodule

// File: tb/vdp_result_checker.sv
// result checker for the vga palette port block: keeps its own copy of the palette and port state
// predicts one result word per accepted request word and compares it with what the block returns
// depends on vdp_pkg for the word layouts, port numbers and the default palette table
module vdp_result_checker import vdp_pkg::*; #(
	parameter int PLANE_SIZE = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   mismatches,
	output int   results_due,
	output int   results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [23:0] colours [256];
	logic        attr_on_data;
	logic [3:0]  attr_sel;
	logic [7:0]  seq_sel;
	logic [7:0]  dac_wr_at;
	logic [7:0]  dac_rd_at;
	logic [1:0]  dac_wr_step;
	logic [1:0]  dac_rd_step;
	logic [15:0] red_green;
	logic [1:0]  plane;
	logic [2:0]  mem_mode;

	rsp_t due_results [$];

	function automatic logic [7:0] ega_scale(input logic hi, input logic lo);
		return 8'({hi, lo}) * 8'd85;
	endfunction

	task automatic clear_state();
		for (int i = 0; i < 256; i++)
			colours[i] = DEFAULT_PALETTE[i];
		attr_on_data = 1'b0;
		attr_sel = '0;
		seq_sel = '0;
		dac_wr_at = '0;
		dac_rd_at = '0;
		dac_wr_step = PHASE_RED;
		dac_rd_step = PHASE_RED;
		red_green = '0;
		plane = '0;
		mem_mode = '0;
	endtask

	// applies one port access to the predicted state and returns the result word it gives
	function automatic rsp_t port_access(input req_t w);
		rsp_t r;
		logic [23:0] entry;
		logic [7:0] comp;
		r = '0;
		if (w.command == CMD_READ) begin
			entry = colours[dac_rd_at];
			if (w.port == PORT_DAC_WIDX) begin
				r.read_data = dac_wr_at;
			end else if (w.port == PORT_DAC_DATA) begin
				case (dac_rd_step)
					PHASE_RED: begin
						r.read_data = {2'b00, entry[23:18]};
						dac_rd_step = PHASE_GREEN;
					end
					PHASE_GREEN: begin
						r.read_data = {2'b00, entry[15:10]};
						dac_rd_step = PHASE_BLUE;
					end
					default: begin
						r.read_data = {2'b00, entry[7:2]};
						dac_rd_step = PHASE_RED;
						dac_rd_at = dac_rd_at + 8'd1;
					end
				endcase
			end else begin
				r.read_data = READ_NONE;
			end
		end else begin
			comp = {w.data[5:0], 2'b00};
			case (w.port)
				PORT_ATTR: begin
					// ega colour bits are rgbRGB, low-intensity bit in the upper half
					if (attr_on_data)
						colours[attr_sel] = {ega_scale(w.data[2], w.data[5]),
							ega_scale(w.data[1], w.data[4]), ega_scale(w.data[0], w.data[3])};
					else
						attr_sel = w.data[3:0];
					attr_on_data = !attr_on_data;
				end
				PORT_SEQ_IDX: begin
					seq_sel = w.data;
				end
				PORT_SEQ_DATA: begin
					if (seq_sel == SEQ_MAP_MASK) begin
						case (w.data[3:0])
							4'b0010: plane = 2'd1;
							4'b0100: plane = 2'd2;
							4'b1000: plane = 2'd3;
							default: plane = 2'd0;
						endcase
					end
					if (seq_sel == SEQ_MEM_MODE)
						mem_mode = w.data[2:0] & 3'b110;
				end
				PORT_DAC_RIDX: begin
					dac_rd_at = w.data;
				end
				PORT_DAC_WIDX: begin
					dac_wr_at = w.data;
				end
				PORT_DAC_DATA: begin
					case (dac_wr_step)
						PHASE_RED: begin
							red_green[15:8] = comp;
							dac_wr_step = PHASE_GREEN;
						end
						PHASE_GREEN: begin
							red_green[7:0] = comp;
							dac_wr_step = PHASE_BLUE;
						end
						default: begin
							colours[dac_wr_at] = {red_green, comp};
							dac_wr_at = dac_wr_at + 8'd1;
							dac_wr_step = PHASE_RED;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
		r.plane_offset = 18'(plane * PLANE_SIZE);
		r.planar_bits = mem_mode;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			clear_state();
			due_results.delete();
			mismatches = 0;
			results_checked = 0;
		end else begin
			// the result word is registered, so a word taken now is never the one returned now
			if (req_valid && req_ready)
				due_results.push_back(port_access(req));
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none due: read_data %h plane_offset %h planar_bits %h",
						$time, rsp.read_data, rsp.plane_offset, rsp.planar_bits);
				end else begin
					want = due_results.pop_front();
					results_checked++;
					if (rsp.read_data !== want.read_data || rsp.plane_offset !== want.plane_offset
						|| rsp.planar_bits !== want.planar_bits) begin
						mismatches++;
						$display("%0t: expected read_data %h plane_offset %h planar_bits %h",
							$time, want.read_data, want.plane_offset, want.planar_bits);
						$display("%0t: actual   read_data %h plane_offset %h planar_bits %h",
							$time, rsp.read_data, rsp.plane_offset, rsp.planar_bits);
					end
				end
			end
		end
		results_due = due_results.size();
	end

endmodule

// File: tb/tb_vga_dac_palette_ports_unit.sv
// top of the palette port testbench: clock, reset, request stimulus and result back-pressure
// depends on vdp_pkg, the vga_dac_palette_ports_unit rtl and vdp_result_checker
module tb_vga_dac_palette_ports_unit import vdp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int PLANE_SIZE = 65536;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int DRAIN_CYCLES = 10;
	localparam int WATCHDOG_NS = 2_000_000;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int mismatches;
	int results_due;
	int results_checked;

	idle_mode_t idle_mode = IDLE_BOTH;
	int words_sent = 0;
	int hold_offs_asked = 0;
	int hold_offs_done = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	vga_dac_palette_ports_unit #(
		.PLANE_SIZE(PLANE_SIZE)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	vdp_result_checker #(
		.PLANE_SIZE(PLANE_SIZE)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.mismatches      (mismatches),
		.results_due     (results_due),
		.results_checked (results_checked)
	);

	function automatic int send_idle_pct(input idle_mode_t m);
		case (m)
			IDLE_SEND: return 48;
			IDLE_BOTH: return 22;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input idle_mode_t m);
		case (m)
			IDLE_RECV: return 48;
			IDLE_BOTH: return 22;
			default:   return 0;
		endcase
	endfunction

	// result side: random stalls, plus a long hold-off whenever the stimulus asks for one
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_offs_done != hold_offs_asked) begin
				rsp_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_offs_done++;
			end
			rsp_ready = ($urandom_range(99) >= recv_stall_pct(idle_mode));
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic cmd, input logic [15:0] port_no, input logic [7:0] value);
		req_t w;
		w.command = cmd;
		w.port = port_no;
		w.data = value;
		while ($urandom_range(99) < send_idle_pct(idle_mode)) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = w;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic out_byte(input logic [15:0] port_no, input logic [7:0] value);
		send_word(CMD_WRITE, port_no, value);
	endtask

	// the data byte of a read carries noise, it must be ignored
	task automatic in_byte(input logic [15:0] port_no);
		send_word(CMD_READ, port_no, 8'($urandom_range(255)));
	endtask

	function automatic logic [15:0] any_port();
		if ($urandom_range(1) == 0)
			return 16'h03C0 | 16'($urandom_range(15));
		return 16'($urandom_range(65535));
	endfunction

	task automatic run_mix(input idle_mode_t m, input int words);
		int target;
		int pick;
		int n;
		logic [7:0] sel;
		idle_mode = m;
		target = words_sent + words;
		while (words_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				// whole colour entries through the dac write port
				out_byte(PORT_DAC_WIDX, 8'($urandom_range(255)));
				n = 3 * $urandom_range(1, 3);
				repeat (n) out_byte(PORT_DAC_DATA, 8'($urandom_range(255)));
			end else if (pick < 40) begin
				out_byte(PORT_DAC_RIDX, 8'($urandom_range(255)));
				n = 3 * $urandom_range(1, 3);
				repeat (n) in_byte(PORT_DAC_DATA);
				if ($urandom_range(3) == 0)
					in_byte(PORT_DAC_WIDX);
			end else if (pick < 55) begin
				out_byte(PORT_ATTR, 8'($urandom_range(255)));
				out_byte(PORT_ATTR, 8'($urandom_range(255)));
			end else if (pick < 70) begin
				case ($urandom_range(3))
					0:       sel = SEQ_MAP_MASK;
					1:       sel = SEQ_MEM_MODE;
					2:       sel = 8'($urandom_range(4));
					default: sel = 8'($urandom_range(255));
				endcase
				out_byte(PORT_SEQ_IDX, sel);
				if ($urandom_range(2) == 0)
					out_byte(PORT_SEQ_DATA, 8'($urandom_range(255)));
				else
					out_byte(PORT_SEQ_DATA, {4'($urandom_range(15)), 4'b0001 << $urandom_range(3)});
			end else if (pick < 80) begin
				// broken colour sequences of one or two components can leave the component phase part way through
				n = $urandom_range(1, 2);
				if ($urandom_range(1) == 0)
					repeat (n) out_byte(PORT_DAC_DATA, 8'($urandom_range(255)));
				else
					repeat (n) in_byte(PORT_DAC_DATA);
			end else begin
				send_word(1'($urandom_range(1)), any_port(), 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: plane select, memory mode, attribute colour, index wrap, unknown ports
		idle_mode = IDLE_BOTH;
		out_byte(PORT_SEQ_IDX, SEQ_MAP_MASK);
		out_byte(PORT_SEQ_DATA, 8'hF8);
		out_byte(PORT_SEQ_DATA, 8'h05);
		out_byte(PORT_SEQ_IDX, SEQ_MEM_MODE);
		out_byte(PORT_SEQ_DATA, 8'hFF);
		out_byte(PORT_SEQ_IDX, 8'hFF);
		out_byte(PORT_SEQ_DATA, 8'h00);
		out_byte(PORT_ATTR, 8'hFF);
		out_byte(PORT_ATTR, 8'hC9);
		out_byte(PORT_DAC_WIDX, 8'hFF);
		out_byte(PORT_DAC_DATA, 8'hFF);
		out_byte(PORT_DAC_DATA, 8'h00);
		out_byte(PORT_DAC_DATA, 8'h15);
		in_byte(PORT_DAC_WIDX);
		out_byte(PORT_DAC_RIDX, 8'hFF);
		repeat (3) in_byte(PORT_DAC_DATA);
		in_byte(PORT_ATTR);
		in_byte(PORT_SEQ_DATA);
		in_byte(PORT_DAC_RIDX);
		in_byte(16'hFFFF);
		out_byte(16'h03CE, 8'hA5);
		out_byte(16'h03CF, 8'h5A);
		in_byte(16'h0000);

		// long result hold-off with the request side pushing back to back
		hold_offs_asked++;
		run_mix(IDLE_NONE, 150);
		run_mix(IDLE_SEND, 200);
		run_mix(IDLE_RECV, 200);
		run_mix(IDLE_BOTH, 200);
		run_mix(IDLE_NONE, 150);
		req_valid = 1'b0;

		while (results_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d port accesses under four idling mixes and a %0d-cycle result hold-off",
			words_sent, HOLD_OFF_CYCLES);
		$display("%0d result words compared, %0d wrong", results_checked, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("timeout with %0d result words outstanding", results_due);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: vga_dac_palette_ports_unit.f
+incdir+sv
sv/vdp_pkg.sv
sv/vga_dac_palette_ports_unit.sv
tb/vdp_result_checker.sv
tb/tb_vga_dac_palette_ports_unit.sv
